FILE: hw/rtl/pps_pkg.sv
// Shared types, codes and constants of the packet protocol and source statistics block.
package pps_pkg;

    localparam int TABLE_SLOTS_DEF = 10;
    localparam int TABLE_SLOTS_MAX = 64;
    localparam int IDX_W = $clog2(TABLE_SLOTS_MAX);

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [2:0] CLS_NONE = 3'd0;
    localparam logic [2:0] CLS_TCP = 3'd1;
    localparam logic [2:0] CLS_UDP = 3'd2;
    localparam logic [2:0] CLS_ICMP = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_HIT = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    typedef struct packed {
        logic        command;
        logic [15:0] frame_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [3:0]  read_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  packet_class;
        logic [2:0]  source_status;
        logic [3:0]  slot_index;
        logic [31:0] slot_address;
        logic [31:0] slot_count;
        logic [31:0] total_count;
        logic [31:0] tcp_count;
        logic [31:0] udp_count;
        logic [31:0] icmp_count;
        logic [3:0]  entries_used;
    } t_out_word;

    typedef struct packed {
        logic             valid;
        logic             cmd_read;
        logic             done;
        logic [2:0]       status;
        logic [IDX_W-1:0] sidx;
        logic [31:0]      saddr;
        logic [31:0]      scount;
        logic [31:0]      addr;
        logic [3:0]       rindex;
        logic [2:0]       pclass;
    } t_tok;

endpackage

FILE: hw/rtl/pps_chan.sv
// Valid/ready channel interface that carries one word per handshake.
interface pps_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport mon (input valid, input data, input ready);
endinterface

FILE: hw/rtl/packet_protocol_and_source_stats.sv
// Top level: packet class counters and a chain of source table slots.
// A word is accepted only while no other word is in the chain.
// The lookup token passes through a register in each slot of the chain and then through the result register.
// A new word is not taken until the last one has walked through all the slots.
// Synchronous active-low reset clears the counters, the fill count and the chain control;
// table slots hold no valid data until written and are never read before that.
module packet_protocol_and_source_stats #(
    parameter int TABLE_SLOTS = pps_pkg::TABLE_SLOTS_DEF
) (
    input logic   i_clk,
    input logic   i_rst_n,
    pps_chan.sink   i_in,
    pps_chan.source o_out
);
    localparam int UW = $clog2(TABLE_SLOTS + 1);

    pps_pkg::t_tok     w_tok [TABLE_SLOTS+1];
    pps_pkg::t_tok     w_exit;
    pps_pkg::t_in_word w_in;
    pps_pkg::t_out_word r_out;
    logic              r_out_valid;
    logic              r_busy;
    logic [UW-1:0]     r_used;
    logic [UW-1:0]     n_used;
    logic [31:0]       r_total;
    logic [31:0]       r_tcp;
    logic [31:0]       r_udp;
    logic [31:0]       r_icmp;
    logic              w_acc;
    logic              w_ipv4;
    logic              w_read;
    logic [2:0]        w_class;
    logic [2:0]        w_status;
    logic [7:0]        w_sidx8;
    logic [7:0]        w_used8;

    assign w_in = i_in.data;
    assign i_in.ready = !r_busy && (!r_out_valid || o_out.ready);
    assign w_acc = i_in.valid && i_in.ready;
    assign w_read = w_in.command == pps_pkg::CMD_READ;
    assign w_ipv4 = w_in.frame_type == pps_pkg::ETH_IPV4;

    always_comb begin
        if (w_read || !w_ipv4) begin
            w_class = pps_pkg::CLS_NONE;
        end else begin
            unique case (w_in.ip_protocol)
                pps_pkg::PROTO_TCP:  w_class = pps_pkg::CLS_TCP;
                pps_pkg::PROTO_UDP:  w_class = pps_pkg::CLS_UDP;
                pps_pkg::PROTO_ICMP: w_class = pps_pkg::CLS_ICMP;
                default:             w_class = pps_pkg::CLS_OTHER;
            endcase
        end
    end

    always_comb begin
        w_tok[0] = '0;
        w_tok[0].valid = w_acc;
        w_tok[0].cmd_read = w_read;
        w_tok[0].done = !w_read && !w_ipv4;
        w_tok[0].status = pps_pkg::ST_NONE;
        w_tok[0].addr = w_in.source_address;
        w_tok[0].rindex = w_in.read_index;
        w_tok[0].pclass = w_class;
    end

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        pps_cell #(
            .IDX(g),
            .UW (UW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_used (r_used),
            .i_tok  (w_tok[g]),
            .o_tok  (w_tok[g+1])
        );
    end

    assign w_exit = w_tok[TABLE_SLOTS];
    assign n_used = r_used
        + UW'(w_exit.valid && w_exit.status == pps_pkg::ST_INSERTED);
    assign w_sidx8 = 8'(w_exit.sidx);
    assign w_used8 = 8'(n_used);

    always_comb begin
        if (w_exit.done) begin
            w_status = w_exit.status;
        end else if (w_exit.cmd_read) begin
            w_status = pps_pkg::ST_EMPTY;
        end else begin
            w_status = pps_pkg::ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
            r_used <= '0;
            r_total <= '0;
            r_tcp <= '0;
            r_udp <= '0;
            r_icmp <= '0;
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_exit.valid) begin
                r_busy <= 1'b0;
            end
            if (w_exit.valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_used <= n_used;
            if (w_acc && !w_read) begin
                r_total <= r_total + 32'd1;
            end
            if (w_acc && w_class == pps_pkg::CLS_TCP) begin
                r_tcp <= r_tcp + 32'd1;
            end
            if (w_acc && w_class == pps_pkg::CLS_UDP) begin
                r_udp <= r_udp + 32'd1;
            end
            if (w_acc && w_class == pps_pkg::CLS_ICMP) begin
                r_icmp <= r_icmp + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit.valid) begin
            r_out.packet_class <= w_exit.pclass;
            r_out.source_status <= w_status;
            r_out.slot_index <= w_sidx8[3:0];
            r_out.slot_address <= w_exit.saddr;
            r_out.slot_count <= w_exit.scount;
            r_out.total_count <= r_total;
            r_out.tcp_count <= r_tcp;
            r_out.udp_count <= r_udp;
            r_out.icmp_count <= r_icmp;
            r_out.entries_used <= w_used8[3:0];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;
endmodule

FILE: hw/rtl/pps_cell.sv
// One source table slot: holds an address and its count and passes the lookup token on.
module pps_cell #(
    parameter int IDX = 0,
    parameter int UW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [UW-1:0] i_used,
    input  pps_pkg::t_tok i_tok,
    output pps_pkg::t_tok o_tok
);
    localparam logic [UW-1:0] C_IDX = UW'(IDX);

    pps_pkg::t_tok r_tok;
    pps_pkg::t_tok n_tok;
    logic [31:0]   r_addr;
    logic [31:0]   r_cnt;
    logic [31:0]   n_cnt;
    logic          n_wr;
    logic          w_occ;
    logic          w_rhit;

    assign w_occ = C_IDX < i_used;
    assign w_rhit = (8'(i_tok.rindex) == 8'(IDX)) && w_occ;

    always_comb begin
        n_tok = i_tok;
        n_wr = 1'b0;
        n_cnt = r_cnt + 32'd1;
        if (i_tok.valid && !i_tok.done) begin
            if (i_tok.cmd_read) begin
                if (w_rhit) begin
                    n_tok.done = 1'b1;
                    n_tok.status = pps_pkg::ST_READ;
                    n_tok.sidx = pps_pkg::IDX_W'(IDX);
                    n_tok.saddr = r_addr;
                    n_tok.scount = r_cnt;
                end
            end else if (w_occ && r_addr == i_tok.addr) begin
                n_wr = 1'b1;
                n_tok.done = 1'b1;
                n_tok.status = pps_pkg::ST_HIT;
                n_tok.sidx = pps_pkg::IDX_W'(IDX);
                n_tok.saddr = i_tok.addr;
                n_tok.scount = n_cnt;
            end else if (C_IDX == i_used) begin
                n_wr = 1'b1;
                n_cnt = 32'd1;
                n_tok.done = 1'b1;
                n_tok.status = pps_pkg::ST_INSERTED;
                n_tok.sidx = pps_pkg::IDX_W'(IDX);
                n_tok.saddr = i_tok.addr;
                n_tok.scount = 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_addr <= i_tok.addr;
            r_cnt <= n_cnt;
        end
    end

    assign o_tok = r_tok;
endmodule

FILE: hw/rtl/pps_checker.sv
// Port-level assertions of the packet statistics block and their binding.
module pps_checker #(
    parameter int TABLE_SLOTS = pps_pkg::TABLE_SLOTS_DEF
) (
    input logic     i_clk,
    input logic     i_rst_n,
    pps_chan.sink   i_in,
    pps_chan.source o_out
);
    logic w_in_acc;
    pps_pkg::t_out_word w_o;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_o = o_out.data;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("Result word changed or dropped while stalled.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !w_in_acc)
        else $error("Two words accepted in back-to-back cycles.");

    a_read_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (w_o.source_status == pps_pkg::ST_READ
            || w_o.source_status == pps_pkg::ST_EMPTY)
        |-> w_o.packet_class == pps_pkg::CLS_NONE)
        else $error("Read result carries a packet class.");

    a_empty_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (w_o.source_status == pps_pkg::ST_NONE
            || w_o.source_status == pps_pkg::ST_FULL
            || w_o.source_status == pps_pkg::ST_EMPTY)
        |-> w_o.slot_index == 4'd0 && w_o.slot_address == 32'd0
            && w_o.slot_count == 32'd0)
        else $error("Slot fields not cleared for a result without a slot.");

    a_full_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && w_o.source_status == pps_pkg::ST_FULL
        |-> w_o.entries_used == 4'(TABLE_SLOTS))
        else $error("Table reported full below its size.");
endmodule

bind packet_protocol_and_source_stats pps_checker #(
    .TABLE_SLOTS(TABLE_SLOTS)
) u_pps_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_in   (i_in),
    .o_out  (o_out)
);
